[rtl/rgbmip_pkg.sv]
// Shared constants, types and channel arithmetic of the RGB565 mip chain downsampler.
`default_nettype none

package rgbmip_pkg;

   localparam int MAX_DIM_LOG2 = 10;
   localparam int MAX_LEVELS   = 8;
   localparam int LINE_DEPTH   = 1 << MAX_DIM_LOG2;

   localparam int PIX_W     = 16;
   localparam int SUM_W     = 19;
   localparam int LOG2_W    = 4;
   localparam int LEVEL_W   = 4;
   localparam int COORD_W   = 9;
   localparam int CNT_W     = MAX_DIM_LOG2;
   localparam int ADDR_W    = MAX_DIM_LOG2;
   localparam int LVL_IDX_W = $clog2(MAX_LEVELS);
   localparam int NLVL_W    = $clog2(MAX_LEVELS + 1);

   // Result word layout: pixel, level, x, y from bit 0 up, padded to whole bytes.
   localparam int RSP_FIELDS_W = PIX_W + LEVEL_W + 2 * COORD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam int CSR_INDEX_W = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_WIDTH_LOG2  = 1'b0,
      CSR_HEIGHT_LOG2 = 1'b1
   } csr_index_type;

   // Limit a log2 dimension to the supported range.
   function automatic logic [LOG2_W-1:0] clamp_log2(input logic [LOG2_W-1:0] v);
      logic [LOG2_W-1:0] r;
      if (v < LOG2_W'(2)) begin
         r = LOG2_W'(2);
      end else if (v > LOG2_W'(MAX_DIM_LOG2)) begin
         r = LOG2_W'(MAX_DIM_LOG2);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // Per-channel sum of two 5-6-5 pixels: red 5:0, green 12:6, blue 18:13.
   function automatic logic [SUM_W-1:0] pair_sum(input logic [PIX_W-1:0] a,
                                                 input logic [PIX_W-1:0] b);
      logic [5:0] r;
      logic [6:0] g;
      logic [5:0] bl;
      r  = {1'b0, a[4:0]}   + {1'b0, b[4:0]};
      g  = {1'b0, a[10:5]}  + {1'b0, b[10:5]};
      bl = {1'b0, a[15:11]} + {1'b0, b[15:11]};
      return {bl, g, r};
   endfunction

   // Add two pair sums, divide each channel by four (floor) and repack.
   function automatic logic [PIX_W-1:0] average_block(input logic [SUM_W-1:0] top,
                                                      input logic [SUM_W-1:0] bottom);
      logic [6:0] r;
      logic [7:0] g;
      logic [6:0] bl;
      r  = {1'b0, top[5:0]}   + {1'b0, bottom[5:0]};
      g  = {1'b0, top[12:6]}  + {1'b0, bottom[12:6]};
      bl = {1'b0, top[18:13]} + {1'b0, bottom[18:13]};
      return {bl[6:2], g[7:2], r[6:2]};
   endfunction

endpackage

`default_nettype wire

[rtl/rgb565_mipmap_box_downsampler_top.sv]
// Top level of the RGB565 mip chain downsampler: level sequencer, line memory and result register.
`default_nettype none

// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid / req_tready  tdata: pixel [15:0]
// rsp_      out        rsp_tvalid / rsp_tready  tdata: pixel, level, x, y; tlast: last
// csr_      in         csr_valid / csr_ready    csr_index: register, csr_data: value
//
// A pixel word is accepted while the sequencer is idle, then a level step parks it; each
// mip level it completes adds a read of the pair sum line memory (registered read data)
// and an averaging step that loads the result register; a cascade that reaches the last
// level skips the closing step, and a frame too small for any level makes no level step.
// A full result register that is not drained holds the sequencer in its averaging step.
// Reset clears the counters, sequencer and result register; the stores need no reset.

module rgb565_mipmap_box_downsampler_top
   import rgbmip_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Input words
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [PIX_W-1:0]       req_tdata,   // pixel [15:0]
   // Result words
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,   // out_pixel [15:0], out_level [19:16],
                                                    // out_x [28:20], out_y [37:29], zero pad
   output logic                        rsp_tlast,
   // Register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [LOG2_W-1:0]      csr_data
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_LEVEL = 3'b010,
      ST_AVG   = 3'b100
   } state_type;

   state_type state_ff, state_in;

   logic [LOG2_W-1:0]    width_log2_ff, width_log2_in;
   logic [LOG2_W-1:0]    height_log2_ff, height_log2_in;
   logic [CNT_W-1:0]     col_ff, col_in;
   logic [CNT_W-1:0]     row_ff, row_in;

   // Working copy of the item being cascaded through the levels.
   logic [PIX_W-1:0]     pix_ff, pix_in;
   logic [CNT_W-1:0]     xs_ff, xs_in;
   logic [CNT_W-1:0]     ys_ff, ys_in;
   logic [LVL_IDX_W-1:0] lvl_ff, lvl_in;
   logic [SUM_W-1:0]     psum_ff, psum_in;

   logic [PIX_W-1:0]     left_ff [MAX_LEVELS];
   logic [SUM_W-1:0]     line_ff [LINE_DEPTH];
   logic [SUM_W-1:0]     line_rd_ff;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [LOG2_W-1:0]    wl, hl;
   logic [LOG2_W-1:0]    wl_m2, hl_m2;
   logic [NLVL_W-1:0]    num_levels;
   logic [CNT_W-1:0]     col_max, row_max;
   logic                 req_acc, csr_acc;
   logic                 left_we, line_we, line_re;
   logic [ADDR_W-1:0]    line_addr;
   logic [ADDR_W:0]      line_base;
   logic [SUM_W-1:0]     cur_sum;
   logic [PIX_W-1:0]     avg_pix;
   logic                 out_free, is_last;
   logic [NLVL_W-1:0]    next_lvl;

   // Number of levels this frame can make: the smaller of the level limit and the
   // halvings that keep each source level wider and taller than four.
   always_comb begin
      wl    = clamp_log2(width_log2_ff);
      hl    = clamp_log2(height_log2_ff);
      wl_m2 = wl - LOG2_W'(2);
      hl_m2 = hl - LOG2_W'(2);
      num_levels = NLVL_W'(MAX_LEVELS);
      if (NLVL_W'(wl_m2) < num_levels) begin
         num_levels = NLVL_W'(wl_m2);
      end
      if (NLVL_W'(hl_m2) < num_levels) begin
         num_levels = NLVL_W'(hl_m2);
      end
      col_max = CNT_W'((CNT_W+1)'(1) << wl) - CNT_W'(1);
      row_max = CNT_W'((CNT_W+1)'(1) << hl) - CNT_W'(1);
   end

   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_tready = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_acc    = csr_valid && csr_ready;
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Each level keeps its pair sum line at its own offset in the shared memory.
   always_comb begin
      line_base = (ADDR_W+1)'(LINE_DEPTH) - ((ADDR_W+1)'(LINE_DEPTH) >> lvl_ff);
      line_addr = ADDR_W'(line_base + (ADDR_W+1)'(xs_ff >> 1));
      cur_sum   = pair_sum(left_ff[lvl_ff], pix_ff);
      avg_pix   = average_block(line_rd_ff, psum_ff);
      out_free  = !rsp_valid_ff || rsp_tready;
      next_lvl  = NLVL_W'(lvl_ff) + NLVL_W'(1);
      // The next level completes a block only if its column and row are both odd.
      is_last   = !((next_lvl < num_levels) && xs_ff[1] && ys_ff[1]);
   end

   always_comb begin
      state_in       = state_ff;
      width_log2_in  = width_log2_ff;
      height_log2_in = height_log2_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      pix_in         = pix_ff;
      xs_in          = xs_ff;
      ys_in          = ys_ff;
      lvl_in         = lvl_ff;
      psum_in        = psum_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_last_in    = rsp_last_ff;
      left_we        = 1'b0;
      line_we        = 1'b0;
      line_re        = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (csr_acc) begin
               case (csr_index_type'(csr_index))
                  CSR_WIDTH_LOG2:  width_log2_in  = csr_data;
                  CSR_HEIGHT_LOG2: height_log2_in = csr_data;
                  default: ;
               endcase
               col_in = '0;
               row_in = '0;
            end else if (req_acc) begin
               pix_in = req_tdata;
               xs_in  = col_ff;
               ys_in  = row_ff;
               lvl_in = '0;
               if (num_levels != '0) begin
                  state_in = ST_LEVEL;
               end
               if (col_ff == col_max) begin
                  col_in = '0;
                  row_in = (row_ff == row_max) ? '0 : row_ff + CNT_W'(1);
               end else begin
                  col_in = col_ff + CNT_W'(1);
               end
            end
         end
         ST_LEVEL: begin
            if (!xs_ff[0]) begin
               left_we  = 1'b1;
               state_in = ST_IDLE;
            end else if (!ys_ff[0]) begin
               line_we  = 1'b1;
               state_in = ST_IDLE;
            end else begin
               line_re  = 1'b1;
               psum_in  = cur_sum;
               state_in = ST_AVG;
            end
         end
         ST_AVG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({ys_ff[COORD_W:1], xs_ff[COORD_W:1],
                                           LEVEL_W'(next_lvl), avg_pix});
               rsp_last_in  = is_last;
               pix_in       = avg_pix;
               xs_in        = xs_ff >> 1;
               ys_in        = ys_ff >> 1;
               lvl_in       = lvl_ff + LVL_IDX_W'(1);
               // The new pixel moves on to the next level's step when that level exists.
               state_in     = (next_lvl < num_levels) ? ST_LEVEL : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         width_log2_ff  <= LOG2_W'(MAX_DIM_LOG2);
         height_log2_ff <= LOG2_W'(MAX_DIM_LOG2);
         col_ff         <= '0;
         row_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         width_log2_ff  <= width_log2_in;
         height_log2_ff <= height_log2_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pix_ff      <= pix_in;
      xs_ff       <= xs_in;
      ys_ff       <= ys_in;
      lvl_ff      <= lvl_in;
      psum_ff     <= psum_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (left_we) begin
         left_ff[lvl_ff] <= pix_ff;
      end
   end

   // Pair sum line memory: one port, registered read data.
   always_ff @(posedge clock) begin
      if (line_we) begin
         line_ff[line_addr] <= cur_sum;
      end
      if (line_re) begin
         line_rd_ff <= line_ff[line_addr];
      end
   end

endmodule

`default_nettype wire

[rtl/rgbmip_checker.sv]
// Port-level checks of the RGB565 mip chain downsampler and their binding to the top level.
`default_nettype none

module rgbmip_checker
   import rgbmip_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic                   rsp_tlast,
   input wire logic                   csr_valid,
   input wire logic                   csr_ready
);

   // A stalled result word keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // Results carry a level from one to the level limit.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[19:16] != '0 && rsp_tdata[19:16] <= LEVEL_W'(MAX_LEVELS))
      else $error("result level out of range");

   // A register write and a pixel are never taken in the same cycle.
   a_csr_excl: assert property (@(posedge clock) disable iff (reset)
      !(csr_valid && csr_ready && req_tvalid && req_tready))
      else $error("register write and pixel accepted together");

   // Reset empties the result register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

endmodule

bind rgb565_mipmap_box_downsampler_top rgbmip_checker u_rgbmip_checker (.*);

`default_nettype wire

[sim/tb_rgb565_mipmap_box_downsampler_top.sv]
// Self-checking stream testbench for the RGB565 mip chain downsampler top level.

module tb_rgb565_mipmap_box_downsampler_top;
   import rgbmip_pkg::*;

   // Run length guards. The limit allows for every result word waiting out the longest
   // receiver stall, every pixel word the longest sender gap, the long hold-off and the
   // idle pauses between settings, and then several times that again.
   localparam int CYCLE_LIMIT  = 800000;
   localparam int TAIL_CYCLES  = 40;     // settling time after the last predicted word, with margin
   localparam int HOLD_AFTER   = 20;     // result words seen before the long hold-off starts
   localparam int HOLD_CYCLES  = 600;
   localparam int RANDOM_WORDS = 330;

   // One expected result word of the mip chain.
   typedef struct packed {
      logic [PIX_W-1:0]   out_pixel;
      logic [LEVEL_W-1:0] out_level;
      logic [COORD_W-1:0] out_x;
      logic [COORD_W-1:0] out_y;
      logic               last;
   } mip_result_t;

   // A register write waiting for the configuration channel.
   typedef struct packed {
      csr_index_type     index;
      logic [LOG2_W-1:0] value;
   } csr_write_t;

   // Every input of the block holds a known value from time zero.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [PIX_W-1:0]       req_tdata  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [LOG2_W-1:0]      csr_data   = '0;

   rgb565_mipmap_box_downsampler_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // Stimulus stores, the predicted result words and run statistics.
   logic [PIX_W-1:0] pixel_feed [$];
   csr_write_t       csr_feed [$];
   mip_result_t      pending_mip_pixels [$];
   bit               no_idle        = 1'b0;
   int               error_count    = 0;
   int               pixels_taken   = 0;
   int               csr_writes     = 0;
   int               results_seen   = 0;
   int               deepest_level  = 0;
   int               cycle_count    = 0;

   // Shadow of the block: its registers, frame position and line stores.
   logic [LOG2_W-1:0] shadow_width_log2;
   logic [LOG2_W-1:0] shadow_height_log2;
   int unsigned       shadow_column;
   int unsigned       shadow_row;
   logic [SUM_W-1:0]  shadow_pair_sums [LINE_DEPTH];
   logic [PIX_W-1:0]  shadow_left_pixels [MAX_LEVELS];

   // Driver and receiver state, each owned by its own clocked block.
   int sender_gap   = 0;
   int sink_stall   = 0;
   bit hold_done    = 1'b0;

   // Mostly no gap, often a short one, now and then a long one. Stretches without any
   // idling come from the no_idle flag, which the stimulus sets for whole settings.
   function automatic int draw_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (no_idle)       return 0;
      if (roll < 55)     return 0;
      if (roll < 90)     return $urandom_range(1, 3);
      if (roll < 97)     return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // Uniform pixels, or pixels biased towards empty and saturated channels so that the
   // channel sums reach their carries.
   function automatic logic [PIX_W-1:0] draw_pixel(input int mode);
      logic [PIX_W-1:0] pick;
      pick = PIX_W'($urandom_range(0, 65535));
      if (mode == 1) begin
         case ($urandom_range(0, 5))
            0: pick = 16'h0000;
            1: pick = 16'hFFFF;
            2: pick = 16'hF800;
            3: pick = 16'h07E0;
            4: pick = 16'h001F;
            default: ;
         endcase
      end
      return pick;
   endfunction

   // Out-of-range exponents behave as the nearest supported one.
   function automatic logic [LOG2_W-1:0] bounded_log2(input logic [LOG2_W-1:0] v);
      if (v < LOG2_W'(2))            return LOG2_W'(2);
      if (v > LOG2_W'(MAX_DIM_LOG2)) return LOG2_W'(MAX_DIM_LOG2);
      return v;
   endfunction

   task automatic report_error(input string what, input int unsigned want,
                               input int unsigned got);
      $display("ERROR at cycle %0d, %s: expected %0h, got %0h", cycle_count, what, want, got);
      error_count++;
   endtask

   // Works out every mip pixel that one base pixel completes. A pixel at an even column
   // of a level is parked as the left half of a pair; at an odd column the pair is summed,
   // parked in the line store on an even row, or averaged with the stored row above on an
   // odd row and passed on as a pixel of the next level.
   task automatic predict_mip_chain(input logic [PIX_W-1:0] base_pixel);
      logic [LOG2_W-1:0] wl;
      logic [LOG2_W-1:0] hl;
      logic [PIX_W-1:0]  p;
      logic [SUM_W-1:0]  ps;
      logic [SUM_W-1:0]  above;
      logic [6:0]        red_sum;
      logic [7:0]        green_sum;
      logic [6:0]        blue_sum;
      int unsigned       levels;
      int unsigned       s;
      int unsigned       xs;
      int unsigned       ys;
      int unsigned       idx;
      int                made_count;
      mip_result_t       made [MAX_LEVELS];
      wl = bounded_log2(shadow_width_log2);
      hl = bounded_log2(shadow_height_log2);
      levels = MAX_LEVELS;
      if (wl - 2 < levels) levels = wl - 2;
      if (hl - 2 < levels) levels = hl - 2;
      p = base_pixel;
      made_count = 0;
      for (s = 0; s < levels; s++) begin
         xs = shadow_column >> s;
         ys = shadow_row >> s;
         if ((xs & 1) == 0) begin
            shadow_left_pixels[s] = p;
            break;
         end
         ps[5:0]   = 6'(shadow_left_pixels[s][4:0])   + 6'(p[4:0]);
         ps[12:6]  = 7'(shadow_left_pixels[s][10:5])  + 7'(p[10:5]);
         ps[18:13] = 6'(shadow_left_pixels[s][15:11]) + 6'(p[15:11]);
         idx = (LINE_DEPTH - (LINE_DEPTH >> s) + (xs >> 1)) % LINE_DEPTH;
         if ((ys & 1) == 0) begin
            shadow_pair_sums[idx] = ps;
            break;
         end
         above     = shadow_pair_sums[idx];
         red_sum   = 7'(above[5:0])   + 7'(ps[5:0]);
         green_sum = 8'(above[12:6])  + 8'(ps[12:6]);
         blue_sum  = 7'(above[18:13]) + 7'(ps[18:13]);
         p = {blue_sum[6:2], green_sum[7:2], red_sum[6:2]};
         made[made_count].out_pixel = p;
         made[made_count].out_level = LEVEL_W'(s + 1);
         made[made_count].out_x     = COORD_W'(xs >> 1);
         made[made_count].out_y     = COORD_W'(ys >> 1);
         made[made_count].last      = 1'b0;
         made_count++;
      end
      for (int i = 0; i < made_count; i++) begin
         made[i].last = (i == made_count - 1);
         pending_mip_pixels.push_back(made[i]);
      end
      shadow_column++;
      if (shadow_column >= (1 << wl)) begin
         shadow_column = 0;
         shadow_row++;
         if (shadow_row >= (1 << hl)) shadow_row = 0;
      end
   endtask

   // Compares one result word with the oldest prediction, field by field.
   task automatic check_mip_result();
      mip_result_t want;
      if (pending_mip_pixels.size() == 0) begin
         report_error("result word with nothing pending", 0, rsp_tdata[PIX_W-1:0]);
         return;
      end
      want = pending_mip_pixels.pop_front();
      if (rsp_tdata[PIX_W-1:0] != want.out_pixel)
         report_error("pixel", want.out_pixel, rsp_tdata[PIX_W-1:0]);
      if (rsp_tdata[PIX_W +: LEVEL_W] != want.out_level)
         report_error("level", want.out_level, rsp_tdata[PIX_W +: LEVEL_W]);
      if (rsp_tdata[PIX_W+LEVEL_W +: COORD_W] != want.out_x)
         report_error("column", want.out_x, rsp_tdata[PIX_W+LEVEL_W +: COORD_W]);
      if (rsp_tdata[PIX_W+LEVEL_W+COORD_W +: COORD_W] != want.out_y)
         report_error("row", want.out_y, rsp_tdata[PIX_W+LEVEL_W+COORD_W +: COORD_W]);
      if (rsp_tlast != want.last)
         report_error("last flag", want.last, rsp_tlast);
      if (int'(want.out_level) > deepest_level) deepest_level = want.out_level;
   endtask

   // Pixel driver. A new word is put on the bus only once the previous one has been taken,
   // and tvalid stays high across back-to-back words, so it changes at most once per edge.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         sender_gap = 0;
      end else if (!req_tvalid || req_tready) begin
         if (sender_gap > 0 || pixel_feed.size() == 0) begin
            if (sender_gap > 0) sender_gap--;
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= pixel_feed.pop_front();
            sender_gap = draw_gap();
         end
      end
   end

   // Register write driver; writes are only queued while the block is idle.
   always @(posedge clock) begin
      csr_write_t w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else if (!csr_valid || csr_ready) begin
         if (csr_feed.size() != 0) begin
            w = csr_feed.pop_front();
            csr_valid <= 1'b1;
            csr_index <= w.index;
            csr_data  <= w.value;
         end else begin
            csr_valid <= 1'b0;
         end
      end
   end

   // Input monitor: every word taken on either input channel updates the shadow. A
   // register write restarts the frame at the origin.
   always @(posedge clock) begin
      if (reset) begin
         shadow_width_log2  = LOG2_W'(MAX_DIM_LOG2);
         shadow_height_log2 = LOG2_W'(MAX_DIM_LOG2);
         shadow_column      = 0;
         shadow_row         = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_WIDTH_LOG2:  shadow_width_log2  = csr_data;
               CSR_HEIGHT_LOG2: shadow_height_log2 = csr_data;
               default: ;
            endcase
            shadow_column = 0;
            shadow_row    = 0;
            csr_writes++;
         end
         if (req_tvalid && req_tready) begin
            predict_mip_chain(req_tdata);
            pixels_taken++;
         end
      end
   end

   // Result receiver. It stalls at random, and once, partway into the deep frame, it holds
   // off for a long stretch so that the result register fills and the input backs up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_mip_result();
            results_seen++;
            if (results_seen == HOLD_AFTER && !hold_done) begin
               hold_done  = 1'b1;
               sink_stall = HOLD_CYCLES;
            end
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            sink_stall = draw_gap();
         end
      end
   end

   // Waits until every pixel word is taken and every predicted result word has arrived,
   // then lets the block finish any pixel that completes no block. Polling on the falling
   // edge keeps it clear of the updates made at the rising edge.
   task automatic wait_idle();
      do @(negedge clock);
      while (pixel_feed.size() != 0 || req_tvalid || pending_mip_pixels.size() != 0);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   // Writes both exponents while the block is idle and waits for both writes to be taken.
   task automatic write_config(input logic [LOG2_W-1:0] w, input logic [LOG2_W-1:0] h);
      csr_write_t cw;
      wait_idle();
      cw.index = CSR_WIDTH_LOG2;
      cw.value = w;
      csr_feed.push_back(cw);
      cw.index = CSR_HEIGHT_LOG2;
      cw.value = h;
      csr_feed.push_back(cw);
      do @(negedge clock);
      while (csr_feed.size() != 0 || csr_valid);
   endtask

   task automatic queue_pixels(input int count, input int mode);
      for (int i = 0; i < count; i++) pixel_feed.push_back(draw_pixel(mode));
   endtask

   // Picks an exponent: mostly small sizes, sometimes the largest or an out-of-range code.
   function automatic logic [LOG2_W-1:0] pick_log2();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 6)  return LOG2_W'($urandom_range(0, 1));
      if (roll < 12) return LOG2_W'($urandom_range(11, 15));
      if (roll < 17) return LOG2_W'(MAX_DIM_LOG2);
      return LOG2_W'($urandom_range(2, 5));
   endfunction

   // Watchdog: a run that stalls or loses result words ends here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("rgb565_mipmap_box_downsampler_top: mismatch");
      $finish;
   end

   initial begin
      logic [LOG2_W-1:0] w;
      logic [LOG2_W-1:0] h;
      int                frame_words;
      int                count;
      int                random_words;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // At the reset size a few words cannot complete any block.
      @(negedge clock);
      pixel_feed.push_back(16'h0000);
      pixel_feed.push_back(16'hFFFF);
      pixel_feed.push_back(draw_pixel(0));

      // Both exponents below range act as 4x4, which makes no level, so the counters move
      // on without a result. The write after it lands mid-frame and restarts at the origin.
      write_config(LOG2_W'(0), LOG2_W'(1));
      pixel_feed.push_back(16'hFFFF);
      pixel_feed.push_back(16'h0000);
      pixel_feed.push_back(16'hF800);
      pixel_feed.push_back(16'h07E0);
      pixel_feed.push_back(16'h001F);

      // Eight wide and a height above range: the first block of saturated pixels must give
      // a saturated result and the second block, all zero, a zero one.
      write_config(LOG2_W'(3), LOG2_W'(15));
      pixel_feed.push_back(16'hFFFF);
      pixel_feed.push_back(16'hFFFF);
      pixel_feed.push_back(16'h0000);
      pixel_feed.push_back(16'h0000);
      queue_pixels(4, 0);
      pixel_feed.push_back(16'hFFFF);
      pixel_feed.push_back(16'hFFFF);
      pixel_feed.push_back(16'h0000);
      pixel_feed.push_back(16'h0000);

      // A 32x32 frame, eight rows deep, reaches the third level. The long receiver hold-off
      // falls inside it while the sender keeps offering words.
      write_config(LOG2_W'(5), LOG2_W'(5));
      queue_pixels(8 * 32, 0);
      random_words = 8 * 32;

      // Random settings: mostly whole frames, often running on into the next one, and now
      // and then a frame cut short by the next register write.
      while (random_words < RANDOM_WORDS) begin
         w = pick_log2();
         h = pick_log2();
         write_config(w, h);
         no_idle = ($urandom_range(0, 3) == 0);
         frame_words = 1 << (int'(bounded_log2(w)) + int'(bounded_log2(h)));
         if (frame_words > 256 || $urandom_range(0, 4) == 0)
            count = $urandom_range(1, 48);
         else
            count = frame_words + $urandom_range(0, 8);
         queue_pixels(count, $urandom_range(0, 1));
         random_words += count;
      end
      no_idle = 1'b0;

      // Nothing more to send: drain and let the block settle before judging the run.
      wait_idle();
      $display("Sent %0d pixel words across %0d register writes; %0d result words checked.",
               pixels_taken, csr_writes, results_seen);
      $display("Deepest mip level produced: %0d.", deepest_level);
      if (error_count == 0 && pending_mip_pixels.size() == 0) begin
         $display("rgb565_mipmap_box_downsampler_top: match");
      end else begin
         $display("rgb565_mipmap_box_downsampler_top: mismatch");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/rgbmip_pkg.sv
rtl/rgb565_mipmap_box_downsampler_top.sv
rtl/rgbmip_checker.sv
sim/tb_rgb565_mipmap_box_downsampler_top.sv
